// File: src/smia_pkg.sv
// shared types and constants of the sign-magnitude integer unit
`default_nettype none
package smia_pkg;

    localparam int WORD_W = 36;  // storage word
    localparam int MAG_W  = 35;  // magnitude bits of a word
    localparam int BODY_W = 37;  // accumulator q, p and magnitude
    localparam int ACC_W  = 38;  // accumulator with sign
    localparam int CNT_W  = 8;   // step count
    localparam int OP_W   = 3;   // operation code

    localparam int MQ_HIGH = 34; // top magnitude bit of mq
    localparam int AC_P    = 35; // p bit of the accumulator

    localparam int S_DATA_W = 48; // operand and count, padded to bytes
    localparam int M_DATA_W = 80; // accumulator and mq, padded to bytes
    localparam int M_USER_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_AC  = 3'd0,
        OP_LOAD_MQ  = 3'd1,
        OP_ADD      = 3'd2,
        OP_ROUND    = 3'd3,
        OP_MULTIPLY = 3'd4,
        OP_DIVIDE   = 3'd5
    } t_op;

    typedef struct packed {
        logic [BODY_W-1:0] sum;
        logic              carry;  // carry out, on subtract set when x >= y
    } t_alu_res;

endpackage
`default_nettype wire

// File: src/smia_alu.sv
// shared 37-bit add / compare-subtract unit
`default_nettype none
module smia_alu (
    input  wire logic [smia_pkg::BODY_W-1:0] i_x,
    input  wire logic [smia_pkg::BODY_W-1:0] i_y,
    input  wire logic                        i_sub,
    output smia_pkg::t_alu_res               o_res
);

    logic [smia_pkg::BODY_W-1:0] w_y;
    logic [smia_pkg::BODY_W:0]   w_full;

    assign w_y    = i_sub ? ~i_y : i_y;
    assign w_full = {1'b0, i_x} + {1'b0, w_y} + {{smia_pkg::BODY_W{1'b0}}, i_sub};

    assign o_res.sum   = w_full[smia_pkg::BODY_W-1:0];
    assign o_res.carry = w_full[smia_pkg::BODY_W];

endmodule
`default_nettype wire

// File: src/sign_magnitude_integer_alu_unit.sv
// top level: sequencer, architectural registers and stream ports of the integer unit
`default_nettype none
// Sign-magnitude integer unit with a 38-bit accumulator (sign, q, p, 35-bit
// magnitude) and a 36-bit mq register, both cleared by reset. Each request
// carries an operation, a storage word and a step count, and yields one result
// with both registers after the operation plus overflow and divide-check flags.
// One shared 37-bit adder does all arithmetic under a small sequencer, so the
// unit takes one request at a time: load ac, load mq, round and add pass from
// idle through execute to the output state (add with unlike signs and a larger
// operand also passes through a reverse-subtract state); multiply and divide
// run a step loop of count steps after execute, one shift-add or
// shift-compare-subtract per cycle through the adder. A zero count, a multiply
// with a zero factor or a refused divide skips the step loop.
// The result sits in an output register; a new request is taken as soon as
// the sequencer has handed its result to that register.
module sign_magnitude_integer_alu_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [35:0] operand, [43:36] count, [47:44] zero
    input  wire logic [smia_pkg::S_DATA_W-1:0] i_s_axis_tdata,
    // [2:0] operation
    input  wire logic [smia_pkg::OP_W-1:0]     i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // [37:0] acc_out, [73:38] mq_out, [79:74] zero
    output logic [smia_pkg::M_DATA_W-1:0]      o_m_axis_tdata,
    // [0] overflow, [1] divide_check
    output logic [smia_pkg::M_USER_W-1:0]      o_m_axis_tuser
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,  // load, add and round ops and multiply/divide setup
        S_FIX  = 6'b000100,  // reverse subtract of an unlike-sign add
        S_MUL  = 6'b001000,
        S_DIV  = 6'b010000,
        S_OUT  = 6'b100000   // hand result to the output register
    } t_state;

    t_state                          r_state, n_state;
    smia_pkg::t_op                   r_op;
    logic [smia_pkg::WORD_W-1:0]     r_opnd;
    logic [smia_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic [smia_pkg::ACC_W-1:0]      r_acc, n_acc;
    logic [smia_pkg::WORD_W-1:0]     r_mq, n_mq;
    logic                            r_neg, n_neg;
    logic                            r_ovf, n_ovf;
    logic                            r_dchk, n_dchk;
    logic                            r_out_valid, n_out_valid;
    logic [smia_pkg::M_DATA_W-1:0]   r_out_data;
    logic [smia_pkg::M_USER_W-1:0]   r_out_user;

    logic [smia_pkg::BODY_W-1:0]     w_x, w_y;
    logic                            w_sub;
    smia_pkg::t_alu_res              w_res;

    logic                            w_accept;
    logic                            w_take;
    logic                            w_load_out;

    // operand views
    logic                            w_ac_sgn;
    logic                            w_op_sgn;
    logic [smia_pkg::MAG_W-1:0]      w_op_mag;
    logic [smia_pkg::MAG_W-1:0]      w_mq_mag;
    logic [smia_pkg::BODY_W-1:0]     w_ac_body;
    logic [smia_pkg::BODY_W-1:0]     w_op_ext;
    logic [smia_pkg::BODY_W-1:0]     w_div_sh;   // ac,mq shifted left one place

    assign w_ac_sgn  = r_acc[smia_pkg::ACC_W-1];
    assign w_op_sgn  = r_opnd[smia_pkg::WORD_W-1];
    assign w_op_mag  = r_opnd[smia_pkg::MAG_W-1:0];
    assign w_mq_mag  = r_mq[smia_pkg::MAG_W-1:0];
    assign w_ac_body = r_acc[smia_pkg::BODY_W-1:0];
    assign w_op_ext  = {2'b00, w_op_mag};
    assign w_div_sh  = {w_ac_body[smia_pkg::BODY_W-2:0], w_mq_mag[smia_pkg::MQ_HIGH]};

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_take          = r_out_valid && i_m_axis_tready;
    assign w_load_out      = (r_state == S_OUT) && (!r_out_valid || i_m_axis_tready);

    // the shared adder's inputs follow the sequencer state
    always_comb begin
        w_x   = w_ac_body;
        w_y   = w_op_ext;
        w_sub = 1'b0;
        case (r_state)
            S_EXEC: begin
                case (r_op)
                    smia_pkg::OP_ADD: begin
                        w_sub = (w_ac_sgn != w_op_sgn);
                    end
                    smia_pkg::OP_ROUND: begin
                        w_y = {{(smia_pkg::BODY_W-1){1'b0}}, 1'b1};
                    end
                    smia_pkg::OP_DIVIDE: begin
                        // dividend against divisor: carry means refuse
                        w_sub = 1'b1;
                    end
                    default: begin
                        w_sub = 1'b0;
                    end
                endcase
            end
            S_FIX: begin
                w_x   = w_op_ext;
                w_y   = w_ac_body;
                w_sub = 1'b1;
            end
            S_MUL: begin
                w_y = w_mq_mag[0] ? w_op_ext : '0;
            end
            S_DIV: begin
                w_x   = w_div_sh;
                w_sub = 1'b1;
            end
            default: begin
                w_sub = 1'b0;
            end
        endcase
    end

    smia_alu u_alu (
        .i_x   (w_x),
        .i_y   (w_y),
        .i_sub (w_sub),
        .o_res (w_res)
    );

    // sequencer and register updates
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_mq        = r_mq;
        n_neg       = r_neg;
        n_ovf       = r_ovf;
        n_dchk      = r_dchk;
        n_out_valid = r_out_valid;
        if (w_take) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cnt   = i_s_axis_tdata[smia_pkg::WORD_W +: smia_pkg::CNT_W];
                    n_ovf   = 1'b0;
                    n_dchk  = 1'b0;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_OUT;
                case (r_op)
                    smia_pkg::OP_LOAD_AC: begin
                        n_acc = {w_op_sgn, 2'b00, w_op_mag};
                    end
                    smia_pkg::OP_LOAD_MQ: begin
                        n_mq = r_opnd;
                    end
                    smia_pkg::OP_ADD: begin
                        if (!w_sub) begin
                            // like signs, overflow when p changes
                            n_acc = {w_ac_sgn, w_res.sum};
                            n_ovf = w_res.sum[smia_pkg::AC_P] ^ w_ac_body[smia_pkg::AC_P];
                        end else if (w_res.carry) begin
                            n_acc = {w_ac_sgn, w_res.sum};
                        end else begin
                            n_state = S_FIX;
                        end
                    end
                    smia_pkg::OP_ROUND: begin
                        if (r_mq[smia_pkg::MQ_HIGH]) begin
                            n_acc = {w_ac_sgn, w_res.sum};
                        end
                    end
                    smia_pkg::OP_MULTIPLY: begin
                        if (r_cnt != '0) begin
                            n_neg = r_mq[smia_pkg::WORD_W-1] ^ w_op_sgn;
                            if (w_op_mag == '0 || w_mq_mag == '0) begin
                                n_acc = {n_neg, {smia_pkg::BODY_W{1'b0}}};
                                n_mq  = {n_neg, {smia_pkg::MAG_W{1'b0}}};
                            end else begin
                                n_acc   = {n_neg, {smia_pkg::BODY_W{1'b0}}};
                                n_mq    = {n_neg, w_mq_mag};
                                n_state = S_MUL;
                            end
                        end
                    end
                    smia_pkg::OP_DIVIDE: begin
                        if (r_cnt != '0) begin
                            if (w_res.carry) begin
                                // dividend not below divisor, zero divisor included
                                n_dchk = 1'b1;
                            end else begin
                                n_neg   = w_ac_sgn ^ w_op_sgn;
                                n_state = S_DIV;
                            end
                        end
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end
            S_FIX: begin
                // operand magnitude larger, sign follows it
                n_acc   = {~w_ac_sgn, w_res.sum};
                n_state = S_OUT;
            end
            S_MUL: begin
                n_acc = {r_neg, 1'b0, w_res.sum[smia_pkg::BODY_W-1:1]};
                n_mq  = {r_neg, w_res.sum[0], w_mq_mag[smia_pkg::MAG_W-1:1]};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == {{(smia_pkg::CNT_W-1){1'b0}}, 1'b1}) begin
                    n_state = S_OUT;
                end
            end
            S_DIV: begin
                if (w_res.carry) begin
                    n_acc = {w_ac_sgn, w_res.sum};
                    n_mq  = {r_neg, w_mq_mag[smia_pkg::MAG_W-2:0], 1'b1};
                end else begin
                    n_acc = {w_ac_sgn, w_div_sh};
                    n_mq  = {r_neg, w_mq_mag[smia_pkg::MAG_W-2:0], 1'b0};
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == {{(smia_pkg::CNT_W-1){1'b0}}, 1'b1}) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_load_out) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_mq        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_mq        <= n_mq;
            r_out_valid <= n_out_valid;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_neg  <= n_neg;
        r_ovf  <= n_ovf;
        r_dchk <= n_dchk;
        if (w_accept) begin
            r_op   <= smia_pkg::t_op'(i_s_axis_tuser);
            r_opnd <= i_s_axis_tdata[smia_pkg::WORD_W-1:0];
        end
        if (w_load_out) begin
            r_out_data <= {{(smia_pkg::M_DATA_W - smia_pkg::ACC_W - smia_pkg::WORD_W){1'b0}},
                           r_mq, r_acc};
            r_out_user <= {r_dchk, r_ovf};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    // an accepted request always enters execution next
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC))
        else $error("request not followed by execution");

    // step loops never run with an exhausted count
    a_mul_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_cnt != '0))
        else $error("multiply step with zero count");

    a_div_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt != '0))
        else $error("divide step with zero count");

    // overflow and divide check never come together
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))
        else $error("overflow and divide check both set");

    // a held result is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |=> $stable(r_out_data))
        else $error("pending result overwritten");

endmodule
`default_nettype wire
